// File: rtl/tone_melody_sequencer_macros.svh
// Assertion helpers used by the checker file.
`ifndef TONE_MELODY_SEQUENCER_MACROS_SVH
`define TONE_MELODY_SEQUENCER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define TMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define TMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tms_pkg.sv
`default_nettype none

package tms_pkg;

   // note table
   localparam int NOTE_DEPTH = 64;
   localparam int IDX_W      = $clog2(NOTE_DEPTH);

   // timer clock and limits
   localparam int CLOCK_HZ  = 48000000;
   localparam int TIMER_MAX = 32'hFFFF;
   localparam int CLK_W     = $clog2(CLOCK_HZ + 1);
   localparam int CNT_W     = $clog2(CLK_W);
   localparam int PRE_W     = $clog2(CLOCK_HZ / TIMER_MAX + 2);

   localparam logic [CLK_W-1:0] CLOCK_VEC = CLK_W'(CLOCK_HZ);

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_PLAY = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  note_index;
      logic [15:0] note_freq_hz;
      logic [15:0] note_duration_ms;
      logic [5:0]  play_start;
      logic [6:0]  play_length;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [CLK_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: rtl/tms_front.sv
`default_nettype none

module tms_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire logic [1:0]      req_type,
   input  wire logic [5:0]      req_note_index,
   input  wire logic [15:0]     req_note_freq_hz,
   input  wire logic [15:0]     req_note_duration_ms,
   input  wire logic [5:0]      req_play_start,
   input  wire logic [6:0]      req_play_length,
   output logic                 cmd_valid,
   output tms_pkg::cmd_type     cmd,
   input  wire logic            cmd_pop
);

   tms_pkg::cmd_type cmd_q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       keep;
   logic       push_q;
   logic       pop_q;

   // drop unused request codes at the door
   always_comb begin
      unique case (req_type) inside
         tms_pkg::REQ_LOAD, tms_pkg::REQ_PLAY, tms_pkg::REQ_TICK: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_q    = req_push && !req_full && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop_q     = cmd_pop && cmd_valid;
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_q;
      rd_ptr_in = rd_ptr_ff ^ pop_q;
      count_in  = count_ff + {1'b0, push_q} - {1'b0, pop_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         cmd_q_ff[wr_ptr_ff] <= '{kind:             req_type,
                                  note_index:       req_note_index,
                                  note_freq_hz:     req_note_freq_hz,
                                  note_duration_ms: req_note_duration_ms,
                                  play_start:       req_play_start,
                                  play_length:      req_play_length};
      end
   end

endmodule

`default_nettype wire

// File: rtl/tms_divider.sv
`default_nettype none

// Restoring divider: CLOCK_HZ / divisor, one quotient bit a cycle.
module tms_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tms_pkg::div_req_type div_req,
   output tms_pkg::div_rsp_type   div_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [tms_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tms_pkg::CLK_W-1:0]   rem_ff, rem_in;
   logic [tms_pkg::CLK_W-1:0]   quo_ff, quo_in;
   logic [tms_pkg::CLK_W-1:0]   dsr_ff, dsr_in;
   logic [tms_pkg::CLK_W:0]     shifted;
   logic [tms_pkg::CLK_W:0]     diff;
   logic                        ge;

   assign shifted = {rem_ff, tms_pkg::CLOCK_VEC[cnt_ff]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = tms_pkg::CNT_W'(tms_pkg::CLK_W - 1);
         rem_in  = '0;
         quo_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[tms_pkg::CLK_W-1:0] : shifted[tms_pkg::CLK_W-1:0];
         quo_in = {quo_ff[tms_pkg::CLK_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp = '{done: done_ff, quotient: quo_ff};

endmodule

`default_nettype wire

// File: rtl/tms_back.sv
`default_nettype none

module tms_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   input  wire tms_pkg::cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output logic [15:0]          rsp_prescale_value,
   output logic [15:0]          rsp_reload_value,
   output logic [14:0]          rsp_compare_value,
   output logic                 rsp_tone_on,
   output logic                 rsp_sound_done
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_NOTE = 3'd2;
   localparam logic [2:0] ST_DIV1 = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DIV2 = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [5:0]                  run_base_ff, run_base_in;
   logic [6:0]                  run_len_ff, run_len_in;
   logic [6:0]                  step_pos_ff, step_pos_in;
   logic                        playing_ff, playing_in;
   logic [31:0]                 now_ff, now_in;
   logic [31:0]                 deadline_ff, deadline_in;
   logic [15:0]                 held_pre_ff, held_pre_in;
   logic [15:0]                 held_rel_ff, held_rel_in;
   logic [15:0]                 freq_ff, freq_in;
   logic [tms_pkg::PRE_W-1:0]   pre_ff, pre_in;
   logic                        emit_tone_ff, emit_tone_in;
   logic                        emit_done_ff, emit_done_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_load;

   logic [15:0]                 out_pre_ff;
   logic [15:0]                 out_rel_ff;
   logic [14:0]                 out_cmp_ff;
   logic                        out_tone_ff;
   logic                        out_done_ff;

   logic [15:0]                 freq_mem [tms_pkg::NOTE_DEPTH];
   logic [15:0]                 dur_mem  [tms_pkg::NOTE_DEPTH];
   logic [15:0]                 rd_freq_ff;
   logic [15:0]                 rd_dur_ff;
   logic                        mem_we;
   logic [tms_pkg::IDX_W-1:0]   wr_addr;
   logic [tms_pkg::IDX_W-1:0]   rd_addr;
   logic [7:0]                  pos_sum;

   logic [31:0]                 tick_diff;
   logic [tms_pkg::PRE_W+15:0]  product;

   tms_pkg::div_req_type        div_req;
   tms_pkg::div_rsp_type        div_rsp;

   // CLOCK_HZ / f / 0xFFFF + 1; split the quotient at bit 16 since
   // q = hi * 0xFFFF + (hi + lo), leaving at most two corrections.
   function automatic logic [tms_pkg::PRE_W-1:0] prescale_of(
      input logic [tms_pkg::CLK_W-1:0] q1
   );
      logic [31:0] q32;
      logic [16:0] hi;
      logic [16:0] sum;
      logic [16:0] q;
      q32 = 32'(q1);
      hi  = {1'b0, q32[31:16]};
      sum = {1'b0, q32[15:0]} + hi;
      if (sum >= 17'(2 * tms_pkg::TIMER_MAX)) begin
         q = hi + 17'd2;
      end else if (sum >= 17'(tms_pkg::TIMER_MAX)) begin
         q = hi + 17'd1;
      end else begin
         q = hi;
      end
      return tms_pkg::PRE_W'(q + 17'd1);
   endfunction

   tms_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign wr_addr   = tms_pkg::IDX_W'(cmd.note_index % tms_pkg::NOTE_DEPTH);
   assign pos_sum   = {2'b00, run_base_ff} + {1'b0, step_pos_ff};
   assign rd_addr   = tms_pkg::IDX_W'(pos_sum % tms_pkg::NOTE_DEPTH);
   assign tick_diff = now_ff + 32'd1 - deadline_ff;
   assign product   = pre_ff * freq_ff;
   assign out_load  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in     = state_ff;
      run_base_in  = run_base_ff;
      run_len_in   = run_len_ff;
      step_pos_in  = step_pos_ff;
      playing_in   = playing_ff;
      now_in       = now_ff;
      deadline_in  = deadline_ff;
      held_pre_in  = held_pre_ff;
      held_rel_in  = held_rel_ff;
      freq_in      = freq_ff;
      pre_in       = pre_ff;
      emit_tone_in = emit_tone_ff;
      emit_done_in = emit_done_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      div_req      = '{start: 1'b0, divisor: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  tms_pkg::REQ_LOAD: mem_we = 1'b1;
                  tms_pkg::REQ_PLAY: begin
                     run_base_in = cmd.play_start;
                     run_len_in  = cmd.play_length;
                     step_pos_in = 7'd0;
                     if (cmd.play_length == 7'd0) begin
                        playing_in   = 1'b0;
                        emit_tone_in = 1'b0;
                        emit_done_in = 1'b1;
                        state_in     = ST_EMIT;
                     end else begin
                        playing_in  = 1'b1;
                        deadline_in = now_ff;
                        state_in    = ST_READ;
                     end
                  end
                  tms_pkg::REQ_TICK: begin
                     now_in = now_ff + 32'd1;
                     if (playing_ff && !tick_diff[31]) begin
                        if (step_pos_ff >= run_len_ff) begin
                           playing_in   = 1'b0;
                           emit_tone_in = 1'b0;
                           emit_done_in = 1'b1;
                           state_in     = ST_EMIT;
                        end else begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_NOTE;
         ST_NOTE: begin
            deadline_in  = deadline_ff + 32'(rd_dur_ff);
            step_pos_in  = step_pos_ff + 7'd1;
            freq_in      = rd_freq_ff;
            emit_done_in = 1'b0;
            if (rd_freq_ff == 16'd0) begin
               emit_tone_in = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               div_req  = '{start: 1'b1, divisor: tms_pkg::CLK_W'(rd_freq_ff)};
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               pre_in   = prescale_of(div_rsp.quotient);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_req  = '{start: 1'b1, divisor: tms_pkg::CLK_W'(product)};
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               held_pre_in  = 16'(pre_ff - tms_pkg::PRE_W'(1));
               held_rel_in  = div_rsp.quotient[15:0];
               emit_tone_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_base_ff  <= '0;
         run_len_ff   <= '0;
         step_pos_ff  <= '0;
         playing_ff   <= 1'b0;
         now_ff       <= '0;
         deadline_ff  <= '0;
         held_pre_ff  <= '0;
         held_rel_ff  <= '0;
         emit_tone_ff <= 1'b0;
         emit_done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_base_ff  <= run_base_in;
         run_len_ff   <= run_len_in;
         step_pos_ff  <= step_pos_in;
         playing_ff   <= playing_in;
         now_ff       <= now_in;
         deadline_ff  <= deadline_in;
         held_pre_ff  <= held_pre_in;
         held_rel_ff  <= held_rel_in;
         emit_tone_ff <= emit_tone_in;
         emit_done_ff <= emit_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      pre_ff  <= pre_in;
      if (out_load) begin
         out_pre_ff  <= held_pre_ff;
         out_rel_ff  <= held_rel_ff;
         out_cmp_ff  <= emit_tone_ff ? held_rel_ff[15:1] : 15'd0;
         out_tone_ff <= emit_tone_ff;
         out_done_ff <= emit_done_ff;
      end
   end

   // note table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         freq_mem[wr_addr] <= cmd.note_freq_hz;
         dur_mem[wr_addr]  <= cmd.note_duration_ms;
      end
      if (state_ff == ST_READ) begin
         rd_freq_ff <= freq_mem[rd_addr];
         rd_dur_ff  <= dur_mem[rd_addr];
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_prescale_value = out_pre_ff;
   assign rsp_reload_value   = out_rel_ff;
   assign rsp_compare_value  = out_cmp_ff;
   assign rsp_tone_on        = out_tone_ff;
   assign rsp_sound_done     = out_done_ff;

endmodule

`default_nettype wire

// File: rtl/tone_melody_sequencer.sv
// Channel   Direction  Handshake          Word
// req_*     in         push / full        load, play or tick request
// rsp_*     out        pop / empty        timer settings of one note or silence
//
// Steps, with the back idle: a load or a tick with no note due only updates state,
// the final silence goes straight to the result stage, a silent note first reads
// the note table, and a tone also needs two serial divides.
// Reset is synchronous and clears all control state but not the note table.
// Each side stalls on its own: a two-word request queue feeds the sequencer,
// and a result register holds the oldest word until it is popped.
`default_nettype none

module tone_melody_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_type,
   input  wire logic [5:0]  req_note_index,
   input  wire logic [15:0] req_note_freq_hz,
   input  wire logic [15:0] req_note_duration_ms,
   input  wire logic [5:0]  req_play_start,
   input  wire logic [6:0]  req_play_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [15:0]      rsp_prescale_value,
   output logic [15:0]      rsp_reload_value,
   output logic [14:0]      rsp_compare_value,
   output logic             rsp_tone_on,
   output logic             rsp_sound_done
);

   // classified request between front and back
   logic             cmd_valid;
   logic             cmd_pop;
   tms_pkg::cmd_type cmd;

   // Front: accept requests, drop unused codes, queue the rest.
   tms_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_type             (req_type),
      .req_note_index       (req_note_index),
      .req_note_freq_hz     (req_note_freq_hz),
      .req_note_duration_ms (req_note_duration_ms),
      .req_play_start       (req_play_start),
      .req_play_length      (req_play_length),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_pop              (cmd_pop)
   );

   // Back: own the note table and the millisecond clock, advance the run,
   // compute timer settings and hold the result word.
   tms_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_prescale_value (rsp_prescale_value),
      .rsp_reload_value   (rsp_reload_value),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_tone_on        (rsp_tone_on),
      .rsp_sound_done     (rsp_sound_done)
   );

endmodule

`default_nettype wire

// File: rtl/tms_checker.sv
`default_nettype none

`include "tone_melody_sequencer_macros.svh"

module tms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [15:0] rsp_prescale_value,
   input wire logic [15:0] rsp_reload_value,
   input wire logic [14:0] rsp_compare_value,
   input wire logic        rsp_tone_on,
   input wire logic        rsp_sound_done
);

   logic [49:0] word_w;
   logic [14:0] half_w;
   logic        wait_w;
   logic        tone_w;
   logic        silent_w;
   logic        done_w;

   assign word_w   = {rsp_empty, rsp_prescale_value, rsp_reload_value, rsp_compare_value,
                      rsp_tone_on, rsp_sound_done};
   assign half_w   = rsp_reload_value[15:1];
   assign wait_w   = !rsp_empty && !rsp_pop;
   assign tone_w   = !rsp_empty && rsp_tone_on;
   assign silent_w = !rsp_empty && !rsp_tone_on;
   assign done_w   = !rsp_empty && rsp_sound_done;

   // hold a waiting word until popped
   `TMS_ASSERT_NXT(a_rsp_hold, clock, reset, wait_w, $stable(word_w), "word moved while held")

   // compare is half the reload while a tone sounds
   `TMS_ASSERT_IMP(a_cmp_half, clock, reset, tone_w, rsp_compare_value == half_w, "bad compare")

   // silence drives compare to zero
   `TMS_ASSERT_IMP(a_cmp_silent, clock, reset, silent_w, rsp_compare_value == '0, "silent tone")

   // the end-of-run word is always silent
   `TMS_ASSERT_IMP(a_done_silent, clock, reset, done_w, !rsp_tone_on, "tone on done word")

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (.*);

`default_nettype wire

// File: tb/tb_tone_melody_sequencer.sv
`default_nettype none

module tb_tone_melody_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   // Hard limits for the run: words to send in the random part, cycles with no
   // handshake before the watchdog gives up, and the settle time at the end.
   localparam int unsigned RANDOM_WORDS = 1750;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned TICK_CAP     = 240;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [15:0] prescale;
      logic [15:0] reload;
      logic [14:0] compare;
      logic        tone_on;
      logic        done;
   } timer_word_type;

   // Tracks the sequencer state and keeps the timer words that are still owed.
   class melody_tracker;
      logic [15:0]    freq_tab [tms_pkg::NOTE_DEPTH];
      logic [15:0]    dur_tab  [tms_pkg::NOTE_DEPTH];
      bit   [5:0]     base;
      bit   [6:0]     len;
      bit   [6:0]     pos;
      bit             active;
      bit   [31:0]    now;
      bit   [31:0]    deadline;
      bit   [15:0]    held_pre;
      bit   [15:0]    held_rel;
      timer_word_type words_due[$];
      int unsigned    words_checked;
      int unsigned    mismatches;

      // Timer settings for one note; a silent note keeps the held period.
      function timer_word_type sound_note(logic [15:0] freq);
         timer_word_type w;
         int unsigned hz;
         int unsigned pre;
         int unsigned rel;
         w  = '0;
         hz = freq;
         if (hz != 0) begin
            pre      = int'(tms_pkg::CLOCK_HZ) / hz / int'(tms_pkg::TIMER_MAX) + 1;
            rel      = int'(tms_pkg::CLOCK_HZ) / pre / hz;
            held_pre = 16'(pre - 1);
            held_rel = 16'(rel);
            w.compare = held_rel[15:1];
            w.tone_on = 1'b1;
         end
         w.prescale = held_pre;
         w.reload   = held_rel;
         return w;
      endfunction

      // Emit the note at the current step, push the deadline out, advance.
      function timer_word_type next_note();
         bit [5:0] entry;
         entry    = base + pos[5:0];
         deadline = deadline + 32'(dur_tab[entry]);
         pos      = pos + 7'd1;
         return sound_note(freq_tab[entry]);
      endfunction

      function timer_word_type end_of_run();
         timer_word_type w;
         w          = '0;
         w.prescale = held_pre;
         w.reload   = held_rel;
         w.done     = 1'b1;
         active     = 1'b0;
         return w;
      endfunction

      function void note_request(tms_pkg::cmd_type c);
         bit [31:0] lag;
         case (c.kind)
            tms_pkg::REQ_LOAD: begin
               freq_tab[c.note_index] = c.note_freq_hz;
               dur_tab[c.note_index]  = c.note_duration_ms;
            end
            tms_pkg::REQ_PLAY: begin
               base = c.play_start;
               len  = c.play_length;
               pos  = '0;
               if (len == 0) begin
                  words_due.push_back(end_of_run());
               end else begin
                  active   = 1'b1;
                  deadline = now;
                  words_due.push_back(next_note());
               end
            end
            tms_pkg::REQ_TICK: begin
               now = now + 32'd1;
               lag = now - deadline;
               // deadline reached when the wrapped lag is non-negative
               if (active && !lag[31]) begin
                  if (pos >= len) words_due.push_back(end_of_run());
                  else words_due.push_back(next_note());
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(timer_word_type got);
         timer_word_type want;
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected timer word pre=%h rel=%h cmp=%h on=%b done=%b",
                        $realtime, got.prescale, got.reload, got.compare, got.tone_on,
                        got.done);
            return;
         end
         want = words_due.pop_front();
         words_checked++;
         if (got.prescale !== want.prescale || got.reload !== want.reload ||
             got.compare !== want.compare || got.tone_on !== want.tone_on ||
             got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: timer word mismatch: want pre=%h rel=%h cmp=%h on=%b done=%b, %s",
                        $realtime, want.prescale, want.reload, want.compare, want.tone_on,
                        want.done, $sformatf("got pre=%h rel=%h cmp=%h on=%b done=%b",
                        got.prescale, got.reload, got.compare, got.tone_on, got.done));
         end
      endfunction
   endclass

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             req_push = 1'b0;
   tms_pkg::cmd_type req_word = '0;
   logic             rsp_pop  = 1'b0;
   logic             req_full;
   logic             rsp_empty;
   wire timer_word_type rsp_seen;

   melody_tracker tracker;

   // Stimulus-side view of the table: which entries hold a note, and their lengths.
   bit          entry_written [tms_pkg::NOTE_DEPTH];
   logic [15:0] entry_ms      [tms_pkg::NOTE_DEPTH];
   bit          no_idle = 1'b0;

   int unsigned loads_sent;
   int unsigned plays_sent;
   int unsigned ticks_sent;
   int unsigned unused_sent;

   tone_melody_sequencer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_type             (req_word.kind),
      .req_note_index       (req_word.note_index),
      .req_note_freq_hz     (req_word.note_freq_hz),
      .req_note_duration_ms (req_word.note_duration_ms),
      .req_play_start       (req_word.play_start),
      .req_play_length      (req_word.play_length),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_prescale_value   (rsp_seen.prescale),
      .rsp_reload_value     (rsp_seen.reload),
      .rsp_compare_value    (rsp_seen.compare),
      .rsp_tone_on          (rsp_seen.tone_on),
      .rsp_sound_done       (rsp_seen.done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hand accepted words to the tracker; both handshakes are seen as they were
   // just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) tracker.note_request(req_word);
         if (rsp_pop && !rsp_empty) tracker.check_result(rsp_seen);
      end
   end

   function automatic int unsigned idle_gap();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // Fill every field with noise; callers overwrite the fields that matter.
   function automatic tms_pkg::cmd_type random_word(input logic [1:0] kind);
      tms_pkg::cmd_type w;
      w.kind             = kind;
      w.note_index       = 6'($urandom);
      w.note_freq_hz     = 16'($urandom);
      w.note_duration_ms = 16'($urandom);
      w.play_start       = 6'($urandom);
      w.play_length      = 7'($urandom);
      return w;
   endfunction

   // Present one word and hold it until the block takes it. Keep push high
   // when the next word follows with no gap.
   task automatic send_word(input tms_pkg::cmd_type w);
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_full !== 1'b0);
      case (w.kind)
         tms_pkg::REQ_LOAD: loads_sent++;
         tms_pkg::REQ_PLAY: plays_sent++;
         tms_pkg::REQ_TICK: ticks_sent++;
         default:           unused_sent++;
      endcase
   endtask

   task automatic load_note(input logic [5:0] idx, input logic [15:0] hz,
                            input logic [15:0] ms);
      tms_pkg::cmd_type w;
      w                  = random_word(tms_pkg::REQ_LOAD);
      w.note_index       = idx;
      w.note_freq_hz     = hz;
      w.note_duration_ms = ms;
      entry_written[idx] = 1'b1;
      entry_ms[idx]      = ms;
      send_word(w);
   endtask

   task automatic start_run(input logic [5:0] first, input logic [6:0] count);
      tms_pkg::cmd_type w;
      w             = random_word(tms_pkg::REQ_PLAY);
      w.play_start  = first;
      w.play_length = count;
      send_word(w);
   endtask

   task automatic tick_once();
      send_word(random_word(tms_pkg::REQ_TICK));
   endtask

   task automatic unused_word();
      send_word(random_word(tms_pkg::REQ_NONE));
   endtask

   function automatic logic [15:0] draw_freq();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(1, 2000));
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly short notes so runs finish; now and then a huge one that only a
   // new play can cut short.
   function automatic logic [15:0] draw_duration();
      case ($urandom_range(0, 31))
         0:       return 16'($urandom);
         1, 2:    return 16'd0;
         default: return 16'($urandom_range(0, 4));
      endcase
   endfunction

   // Prefer entries not yet written so the table fills up early.
   function automatic logic [5:0] pick_index();
      int unsigned open_slots[$];
      int unsigned i;
      for (i = 0; i < tms_pkg::NOTE_DEPTH; i++)
         if (!entry_written[i]) open_slots.push_back(i);
      if (open_slots.size() != 0 && $urandom_range(0, 1) == 0)
         return 6'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
      return 6'($urandom);
   endfunction

   task automatic random_load();
      load_note(pick_index(), draw_freq(), draw_duration());
   endtask

   // Start a run that only touches written entries; report its length in ms.
   task automatic random_run(output int unsigned span);
      int unsigned pool[$];
      int unsigned i;
      int unsigned first;
      int unsigned reach;
      int unsigned count;
      span = 0;
      for (i = 0; i < tms_pkg::NOTE_DEPTH; i++)
         if (entry_written[i]) pool.push_back(i);
      first = pool[$urandom_range(0, pool.size() - 1)];
      if (pool.size() == tms_pkg::NOTE_DEPTH) begin
         reach = 127;
      end else begin
         reach = 0;
         while (entry_written[(first + reach) % tms_pkg::NOTE_DEPTH]) reach++;
      end
      case ($urandom_range(0, 9))
         0:       count = 0;
         1:       count = $urandom_range(1, reach);
         default: count = $urandom_range(1, reach < 6 ? reach : 6);
      endcase
      for (i = 0; i < count; i++)
         span += entry_ms[(first + i) % tms_pkg::NOTE_DEPTH];
      start_run(6'(first), 7'(count));
   endtask

   // Drain side: wait a drawn number of cycles, then pop until a word is taken.
   initial begin : pop_side
      int unsigned gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_gap();
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
      end
   end

   // End the run if neither side moves a word for too long.
   initial begin : watchdog
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned sent_before;
      int unsigned span;
      int unsigned ticks_left;
      int unsigned n;
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // zero-length play straight out of reset: final silence with reset period
      start_run(6'd0, 7'd0);
      load_note(6'd0,  16'd1,     16'd1);
      load_note(6'd63, 16'hFFFF,  16'd0);
      // silent note as the last step of a run
      load_note(6'd1,  16'd0,     16'd2);
      load_note(6'd2,  16'd440,   16'hFFFF);
      load_note(6'd42, 16'h8000,  16'h5555);
      // tick while idle, then a word of the unused kind
      tick_once();
      unused_word();
      // run that wraps past the top of the table
      start_run(6'd63, 7'd3);
      repeat (5) tick_once();
      start_run(6'd0, 7'd0);
      // long note cut short by a new play
      start_run(6'd2, 7'd1);
      tick_once();
      start_run(6'd0, 7'd1);
      repeat (2) tick_once();

      // Random part: mostly load, play, then tick the run out, with noise.
      sent_before = loads_sent + plays_sent + ticks_sent;
      while (loads_sent + plays_sent + ticks_sent - sent_before < RANDOM_WORDS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         n = $urandom_range(1, 4);
         repeat (n) random_load();
         random_run(span);
         ticks_left = span + 2 > TICK_CAP ? TICK_CAP : span + 2;
         while (ticks_left != 0) begin
            case ($urandom_range(0, 99))
               0, 1, 2: unused_word();
               3, 4:    random_load();
               5, 6: begin
                  // drop the current run and start another
                  random_run(span);
                  ticks_left = span + 2 > TICK_CAP ? TICK_CAP : span + 2;
               end
               default: begin
                  tick_once();
                  ticks_left--;
               end
            endcase
         end
      end
      no_idle = 1'b0;

      // Release the input side, wait for owed words, then let the block settle.
      req_push <= 1'b0;
      @(posedge clock);
      while (tracker.words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d loads, %0d plays, %0d ticks and %0d unused words",
               loads_sent, plays_sent, ticks_sent, unused_sent);
      $display("Checked %0d timer words, %0d mismatches", tracker.words_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.words_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/tms_pkg.sv
rtl/tms_front.sv
rtl/tms_divider.sv
rtl/tms_back.sv
rtl/tone_melody_sequencer.sv
rtl/tms_checker.sv
tb/tb_tone_melody_sequencer.sv
